>>> hw/rtl/cctl_pkg.sv
// Shared types and constants for the character class table lookup.
// Holds the command record passed from front to back, mode and register codes.
// No dependencies.
package cctl_pkg;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_TEST   = 3'd1;
  localparam logic [2:0] MODE_CLASS  = 3'd2;
  localparam logic [2:0] MODE_UPPER  = 3'd3;
  localparam logic [2:0] MODE_LOWER  = 3'd4;
  localparam logic [2:0] MODE_NARROW = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_FLAG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_FLAG  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_FLAG = 2'd3;

  localparam logic [15:0] LOWER_FLAG_RST  = 16'd2;
  localparam logic [15:0] UPPER_FLAG_RST  = 16'd1;
  localparam logic [15:0] NARROW_FLAG_RST = 16'd32768;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_QUERY,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  mode;
    logic [15:0] code;
    logic [15:0] qmask;
    logic [7:0]  dbyte;
    logic [7:0]  idx;
    logic [15:0] cls;
    logic [15:0] other;
    logic [7:0]  nbyte;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [15:0] lower;
    logic [15:0] upper;
    logic [15:0] narrow;
  } flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINAL,
    ST_DFLT,
    ST_DONE
  } bk_state_t;

endpackage

>>> hw/rtl/cctl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cctl_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/cctl_front.sv
// Front end: accepts input transfers, unpacks and classifies them into commands.
// Depends on cctl_pkg.
module cctl_front #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned CODE_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [cctl_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tlast,
  output logic                                 fr_valid,
  output cctl_pkg::cmd_t                       fr_cmd,
  input  logic                                 q_ready
);
  import cctl_pkg::*;

  localparam logic [31:0] CODE_MASK = (32'h1 << CODE_BITS) - 32'h1;

  cmd_t        dec;
  logic [31:0] code_m;
  logic        fr_valid_r;
  cmd_t        fr_cmd_r;

  always_comb begin
    dec.mode  = in_tdata[2:0];
    code_m    = 32'(in_tdata[18:3]) & CODE_MASK;
    dec.code  = code_m[15:0];
    dec.qmask = in_tdata[34:19];
    dec.dbyte = in_tdata[42:35];
    dec.idx   = in_tdata[50:43];
    dec.cls   = in_tdata[66:51];
    dec.other = in_tdata[82:67];
    dec.nbyte = in_tdata[90:83];
    dec.last  = in_tlast;
    unique case (dec.mode) inside
      MODE_LOAD: begin
        dec.kind = (32'(dec.idx) < 32'(TABLE_DEPTH)) ? KIND_LOAD : KIND_NONE;
      end
      MODE_TEST, MODE_CLASS, MODE_UPPER, MODE_LOWER, MODE_NARROW: begin
        dec.kind = KIND_QUERY;
      end
      default: begin
        dec.kind = KIND_NONE;
      end
    endcase
  end

  assign in_tready = !fr_valid_r || q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      fr_valid_r <= 1'b1;
    end else if (q_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      fr_cmd_r <= dec;
    end
  end

  assign fr_valid = fr_valid_r;
  assign fr_cmd   = fr_cmd_r;

endmodule

>>> hw/rtl/cctl_queue.sv
// Short command queue between front and back end.
// Depends on cctl_pkg.
module cctl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cctl_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cctl_pkg::cmd_t pop_cmd
);
  import cctl_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/cctl_back.sv
// Back end: table RAM, binary search sequencer and output register.
// Depends on cctl_pkg and cctl_ram.
module cctl_back #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned CODE_BITS   = 16,
  parameter int unsigned CLASS_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  cctl_pkg::cmd_t                     q_cmd,
  input  cctl_pkg::flags_t                   flags,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     dflt,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cctl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);
  import cctl_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CLS_LO = CODE_BITS;
  localparam int unsigned OTH_LO = CODE_BITS + CLASS_BITS;
  localparam int unsigned NB_LO  = 2 * CODE_BITS + CLASS_BITS;
  localparam int unsigned ENT_W  = NB_LO + 8;

  bk_state_t        state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] len_r, len_nxt;
  logic [ENT_W-1:0] ent_r, ent_nxt;
  logic             hit_r, hit_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  logic [IDX_W-1:0] half;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] step_first;
  logic [IDX_W-1:0] step_len;
  logic             less;
  logic             key_eq;
  logic             out_load;

  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic [31:0] cls32;
  logic [31:0] nf32;
  logic [15:0] res_value;
  logic [15:0] res_class;
  logic        res_match;
  logic        res_found;

  assign ram_waddr = IDX_W'(q_cmd.idx);
  assign ram_wdata = {q_cmd.nbyte, CODE_BITS'(32'(q_cmd.other)),
                      CLASS_BITS'(32'(q_cmd.cls)), CODE_BITS'(32'(q_cmd.code))};

  cctl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    first_r <= first_nxt;
    len_r   <= len_nxt;
    ent_r   <= ent_nxt;
    hit_r   <= hit_nxt;
  end

  always_comb begin
    half       = len_r >> 1;
    mid        = IDX_W'(first_r + half);
    less       = 32'(ram_rdata[CODE_BITS-1:0]) < 32'(cmd_r.code);
    key_eq     = 32'(ram_rdata[CODE_BITS-1:0]) == 32'(cmd_r.code);
    step_first = less ? IDX_W'(mid + IDX_W'(1)) : first_r;
    step_len   = less ? IDX_W'(len_r - half - IDX_W'(1)) : half;

    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    ent_nxt   = ent_r;
    hit_nxt   = hit_r;
    q_ready   = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = first_r;
    out_load  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          cmd_nxt = q_cmd;
          hit_nxt = 1'b0;
          unique case (q_cmd.kind)
            KIND_LOAD: begin
              ram_we    = 1'b1;
              state_nxt = ST_DONE;
            end
            KIND_QUERY: begin
              first_nxt = '0;
              len_nxt   = dflt;
              ram_raddr = dflt >> 1;
              state_nxt = (dflt != '0) ? ST_STEP : ST_FINAL;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_STEP: begin
        first_nxt = step_first;
        len_nxt   = step_len;
        ram_raddr = IDX_W'(step_first + (step_len >> 1));
        state_nxt = (step_len != '0) ? ST_STEP : ST_FINAL;
      end
      ST_FINAL: begin
        if (first_r == dflt) begin
          ent_nxt   = ram_rdata;
          state_nxt = ST_DONE;
        end else if (key_eq) begin
          ent_nxt   = ram_rdata;
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ram_raddr = dflt;
          state_nxt = ST_DFLT;
        end
      end
      ST_DFLT: begin
        ent_nxt   = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result fields from the selected entry
  always_comb begin
    cls32     = 32'(ent_r[CLS_LO +: CLASS_BITS]);
    nf32      = 32'(flags.narrow);
    res_value = '0;
    res_class = '0;
    res_match = 1'b0;
    res_found = 1'b0;
    if (cmd_r.kind == KIND_QUERY) begin
      res_class = 16'(cls32 & ~nf32);
      res_found = hit_r;
      case (cmd_r.mode)
        MODE_TEST: begin
          res_match = |(cls32 & 32'(cmd_r.qmask));
        end
        MODE_UPPER: begin
          res_value = |(cls32 & 32'(flags.lower)) ?
                      16'(32'(ent_r[OTH_LO +: CODE_BITS])) : cmd_r.code;
        end
        MODE_LOWER: begin
          res_value = |(cls32 & 32'(flags.upper)) ?
                      16'(32'(ent_r[OTH_LO +: CODE_BITS])) : cmd_r.code;
        end
        MODE_NARROW: begin
          res_value = |(cls32 & nf32) ? {8'b0, ent_r[NB_LO +: 8]} : {8'b0, cmd_r.dbyte};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'b0, res_found, res_match, res_class, res_value};
      out_last_r <= cmd_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/char_class_table_lookup.sv
// Character class table lookup: sorted table, binary search, per-item answer.
// A query that misses and ends short of the default entry reads the default entry as well.
// The back end takes one item at a time and accepts the next only once the last result
// has been loaded into the output register; one RAM read per halving step.
// Sync reset (rst_n low) clears handshakes and returns config registers to their reset values; table unchanged.
module char_class_table_lookup #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned CODE_BITS   = 16,
  parameter int unsigned CLASS_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: mode[2:0], char_code[18:3], query_mask[34:19], default_byte[42:35],
  //   entry_index[50:43], entry_class[66:51], entry_other_case[82:67],
  //   entry_byte[90:83], zero pad[95:91]; in_tlast: last_of_range
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cctl_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  // out_tdata: out_value[15:0], out_class[31:16], out_match[32], out_found[33],
  //   zero pad[39:34]; out_tlast: out_last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cctl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [cctl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cctl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cctl_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic             fr_valid;
  cmd_t             fr_cmd;
  logic             q_push_ready;
  logic             q_pop_valid;
  logic             q_pop_ready;
  cmd_t             q_pop_cmd;
  flags_t           flags_r;
  logic [IDX_W-1:0] dflt_r, dflt_nxt;
  logic [31:0]      cnt32;
  logic [31:0]      used;

  // clamp entry count to 1..TABLE_DEPTH, keep index of default entry
  always_comb begin
    cnt32 = 32'(cfg_wdata[8:0]);
    if (cnt32 == 32'd0) begin
      used = 32'd1;
    end else if (cnt32 > 32'(TABLE_DEPTH)) begin
      used = 32'(TABLE_DEPTH);
    end else begin
      used = cnt32;
    end
    dflt_nxt = IDX_W'(used - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r         <= '0;
      flags_r.lower  <= LOWER_FLAG_RST;
      flags_r.upper  <= UPPER_FLAG_RST;
      flags_r.narrow <= NARROW_FLAG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT: dflt_r         <= dflt_nxt;
        REG_LOWER_FLAG:  flags_r.lower  <= cfg_wdata;
        REG_UPPER_FLAG:  flags_r.upper  <= cfg_wdata;
        REG_NARROW_FLAG: flags_r.narrow <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  cctl_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CODE_BITS  (CODE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .fr_valid (fr_valid),
    .fr_cmd   (fr_cmd),
    .q_ready  (q_push_ready)
  );

  cctl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fr_valid),
    .push_ready(q_push_ready),
    .push_cmd  (fr_cmd),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd)
  );

  cctl_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CODE_BITS  (CODE_BITS),
    .CLASS_BITS (CLASS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_pop_valid),
    .q_ready   (q_pop_ready),
    .q_cmd     (q_pop_cmd),
    .flags     (flags_r),
    .dflt      (dflt_r),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid && !q_push_ready |=> fr_valid)
    else $error("front command dropped while queue full");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_ready |-> q_pop_valid)
    else $error("back end popped an empty queue");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> fr_valid)
    else $error("accepted input transfer not held in front register");

endmodule

>>> sim/char_class_table_lookup_tb.sv
// Testbench for char_class_table_lookup: directed transfers checked against typed answers, and random
// stream transfers checked against an in-bench predictor of the table search and answer modes.
// Depends on cctl_pkg and char_class_table_lookup.
module char_class_table_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cctl_pkg::*;

  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam int unsigned DEPTH       = 256;
  localparam int unsigned SETTLE_CYC  = 24;
  localparam int unsigned HOLD_CYC    = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  nbyte;
    logic [15:0] other;
    logic [15:0] cls;
    logic [7:0]  idx;
    logic [7:0]  dbyte;
    logic [15:0] qmask;
    logic [15:0] code;
    logic [2:0]  mode;
  } cmd_word_t;

  typedef struct packed {
    logic      last;
    cmd_word_t w;
  } char_req_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic        found;
    logic        match;
    logic [15:0] cls;
    logic [15:0] value;
  } ans_word_t;

  typedef struct packed {
    logic      last;
    ans_word_t w;
  } char_ans_t;

  typedef struct {
    char_req_t req;
    bit        typed;
    char_ans_t ans;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  char_class_table_lookup i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [15:0] tab_code  [DEPTH];
  logic [15:0] tab_cls   [DEPTH];
  logic [15:0] tab_other [DEPTH];
  logic [7:0]  tab_byte  [DEPTH];
  logic [8:0]  count_cfg;
  logic [15:0] lower_cfg, upper_cfg, narrow_cfg;

  char_ans_t answer_q[$];
  dir_row_t  dir_rows[$];

  int unsigned err_cnt = 0;
  int unsigned n_loads = 0, n_queries = 0, n_hits = 0, n_results = 0;
  int unsigned snd_idle_pct = 0, rcv_stall_pct = 0;
  int unsigned hold_req = 0, hold_ack = 0, hold_left = 0;
  int unsigned stall_cycles = 0;

  function automatic int unsigned used_entries();
    if (count_cfg == 0) return 1;
    if (count_cfg > DEPTH) return DEPTH;
    return count_cfg;
  endfunction

  function automatic char_ans_t char_engine_answer(input char_req_t r);
    char_ans_t   a;
    int unsigned dflt, first, len, half, mid, sel;
    logic        hit;
    a = '0;
    a.last = r.last;
    if (r.w.mode == MODE_LOAD) begin
      tab_code[r.w.idx]  = r.w.code;
      tab_cls[r.w.idx]   = r.w.cls;
      tab_other[r.w.idx] = r.w.other;
      tab_byte[r.w.idx]  = r.w.nbyte;
    end else if (r.w.mode <= MODE_NARROW) begin
      dflt = used_entries() - 1;
      first = 0;
      len = dflt;
      while (len > 0) begin
        half = len / 2;
        mid = first + half;
        if (tab_code[mid] < r.w.code) begin
          first = mid + 1;
          len = len - half - 1;
        end else begin
          len = half;
        end
      end
      hit = (first < dflt) && (tab_code[first] == r.w.code);
      sel = hit ? first : dflt;
      a.w.found = hit;
      a.w.cls = tab_cls[sel] & ~narrow_cfg;
      case (r.w.mode)
        MODE_TEST:   a.w.match = |(tab_cls[sel] & r.w.qmask);
        MODE_UPPER:  a.w.value = |(tab_cls[sel] & lower_cfg) ? tab_other[sel] : r.w.code;
        MODE_LOWER:  a.w.value = |(tab_cls[sel] & upper_cfg) ? tab_other[sel] : r.w.code;
        MODE_NARROW: a.w.value = |(tab_cls[sel] & narrow_cfg) ? {8'h00, tab_byte[sel]}
                                                             : {8'h00, r.w.dbyte};
        default: ;
      endcase
    end
    return a;
  endfunction

  function automatic char_req_t mk_req(input logic [2:0] mode, input logic [15:0] code,
                                       input logic [15:0] qmask, input logic [7:0] dbyte,
                                       input logic [7:0] idx, input logic [15:0] cls,
                                       input logic [15:0] other, input logic [7:0] nbyte,
                                       input logic last);
    char_req_t r;
    r = '0;
    r.w.mode = mode;   r.w.code = code;   r.w.qmask = qmask; r.w.dbyte = dbyte;
    r.w.idx = idx;     r.w.cls = cls;     r.w.other = other; r.w.nbyte = nbyte;
    r.last = last;
    return r;
  endfunction

  function automatic char_ans_t mk_ans(input logic [15:0] value, input logic [15:0] cls,
                                       input logic match, input logic found,
                                       input logic last);
    char_ans_t a;
    a = '0;
    a.w.value = value; a.w.cls = cls; a.w.match = match; a.w.found = found;
    a.last = last;
    return a;
  endfunction

  function automatic char_req_t rand_req();
    char_req_t   r;
    int unsigned p, n;
    r.w = {$urandom(), $urandom(), $urandom()};
    r.w.pad = '0;
    r.last = 1'($urandom_range(1));
    p = $urandom_range(99);
    n = used_entries();
    if (p < 8) begin
      r.w.mode = MODE_LOAD;
      // mostly keep the order of the searchable part, now and then break it
      if (p >= 3) r.w.code = tab_code[r.w.idx];
    end else if (p < 12) begin
      r.w.mode = $urandom_range(1) ? MODE_RSVD6 : MODE_RSVD7;
    end else begin
      r.w.mode = 3'($urandom_range(MODE_NARROW, MODE_TEST));
      if (n > 1 && $urandom_range(99) < 60) begin
        r.w.code = tab_code[$urandom_range(n - 2)];
        if ($urandom_range(4) == 0) r.w.code = r.w.code + 16'($urandom_range(1) ? 1 : -1);
      end
    end
    return r;
  endfunction

  task automatic send_req(input char_req_t r, input char_ans_t typed_ans, input bit typed);
    char_ans_t a;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = r.w;
    in_tlast = r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    a = char_engine_answer(r);
    if (r.w.mode == MODE_LOAD) n_loads++;
    else if (r.w.mode <= MODE_NARROW) begin
      n_queries++;
      if (a.w.found) n_hits++;
    end
    answer_q.push_back(typed ? typed_ans : a);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_ENTRY_COUNT: count_cfg = val[8:0];
      REG_LOWER_FLAG:  lower_cfg = val;
      REG_UPPER_FLAG:  upper_cfg = val;
      REG_NARROW_FLAG: narrow_cfg = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [15:0] cnt, input logic [15:0] lo,
                           input logic [15:0] up, input logic [15:0] nar,
                           input int unsigned snd_pct, input int unsigned rcv_pct,
                           input int unsigned n_items, input bit hold);
    wait_drained();
    write_reg(REG_ENTRY_COUNT, cnt);
    write_reg(REG_LOWER_FLAG, lo);
    write_reg(REG_UPPER_FLAG, up);
    write_reg(REG_NARROW_FLAG, nar);
    @(negedge clk);
    cfg_we = 1'b0;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    if (hold) hold_req++;
    repeat (n_items) send_req(rand_req(), '0, 1'b0);
  endtask

  function automatic logic [15:0] one_hot16();
    return 16'h0001 << $urandom_range(15);
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom());
  endfunction

  // receiver ready, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    char_ans_t want;
    ans_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      n_results++;
      if (answer_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("ERROR: result with nothing expected: value=%h class=%h match=%b found=%b",
                   got.value, got.cls, got.match, got.found);
      end else begin
        want = answer_q.pop_front();
        if (got.value !== want.w.value || got.cls !== want.w.cls ||
            got.match !== want.w.match || got.found !== want.w.found ||
            out_tlast !== want.last) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("ERROR: result %0d exp value=%h class=%h match=%b found=%b last=%b, got %s",
                     n_results, want.w.value, want.w.cls, want.w.match, want.w.found,
                     want.last, $sformatf("value=%h class=%h match=%b found=%b last=%b",
                     got.value, got.cls, got.match, got.found, out_tlast));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("timeout: no transfer in %0d cycles, %0d results outstanding",
                 STALL_LIMIT, answer_q.size());
        $display("char_class_table_lookup test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned i;
    char_req_t   r;
    count_cfg = 9'd1;
    lower_cfg = LOWER_FLAG_RST;
    upper_cfg = UPPER_FLAG_RST;
    narrow_cfg = NARROW_FLAG_RST;

    // reset settings: one entry, slot 0 is the default for every query
    dir_rows.push_back('{mk_req(MODE_LOAD, 16'h0041, 16'h0000, 8'h00, 8'h00, 16'h8001,
                                16'h0061, 8'h41, 1'b0), 1'b1, mk_ans(16'h0, 16'h0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_TEST, 16'h0041, 16'h0001, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h0, 16'h0001, 1, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_TEST, 16'h0041, 16'h0000, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b1), 1'b1, mk_ans(16'h0, 16'h0001, 0, 0, 1)});
    dir_rows.push_back('{mk_req(MODE_TEST, 16'h1234, 16'h8000, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h0, 16'h0001, 1, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_CLASS, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                16'hFFFF, 8'hFF, 1'b1), 1'b1, mk_ans(16'h0, 16'h0001, 0, 0, 1)});
    dir_rows.push_back('{mk_req(MODE_UPPER, 16'h0041, 16'h0, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h0041, 16'h0001, 0, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_LOWER, 16'h0041, 16'h0, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h0061, 16'h0001, 0, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_LOWER, 16'h0000, 16'h0, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b1), 1'b1, mk_ans(16'h0061, 16'h0001, 0, 0, 1)});
    dir_rows.push_back('{mk_req(MODE_NARROW, 16'h0041, 16'h0, 8'h7E, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h0041, 16'h0001, 0, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_RSVD6, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                16'hFFFF, 8'hFF, 1'b1), 1'b1, mk_ans(16'h0, 16'h0, 0, 0, 1)});
    dir_rows.push_back('{mk_req(MODE_RSVD7, 16'h0041, 16'hFFFF, 8'hFF, 8'h00, 16'hFFFF,
                                16'hFFFF, 8'hFF, 1'b0), 1'b1, mk_ans(16'h0, 16'h0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_LOAD, 16'hFFFF, 16'h0, 8'h00, 8'hFF, 16'hFFFF,
                                16'hFFFF, 8'hFF, 1'b1), 1'b1, mk_ans(16'h0, 16'h0, 0, 0, 1)});
    dir_rows.push_back('{mk_req(MODE_LOAD, 16'h0000, 16'hFFFF, 8'hFF, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h0, 16'h0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_NARROW, 16'h0000, 16'h0, 8'hFF, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h00FF, 16'h0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_NARROW, 16'h0000, 16'h0, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h0000, 16'h0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(MODE_UPPER, 16'hFFFF, 16'h0, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b1), 1'b1, mk_ans(16'hFFFF, 16'h0, 0, 0, 1)});
    dir_rows.push_back('{mk_req(MODE_TEST, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 16'h0, 16'h0,
                                8'h0, 1'b0), 1'b1, mk_ans(16'h0, 16'h0, 0, 0, 0)});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[k]) send_req(dir_rows[k].req, dir_rows[k].ans, dir_rows[k].typed);

    // fill every slot, ascending codes; slot 255 becomes the default at full size
    for (i = 0; i < DEPTH; i++) begin
      r = rand_req();
      r.w.mode = MODE_LOAD;
      r.w.idx = 8'(i);
      r.w.code = 16'(i * 256 + $urandom_range(255));
      send_req(r, '0, 1'b0);
    end

    run_phase(16'd256, LOWER_FLAG_RST, UPPER_FLAG_RST, NARROW_FLAG_RST, 0, 0, 175, 1'b0);
    run_phase(16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 67, 0, 175, 1'b0);
    run_phase(16'd0, 16'h0000, 16'h0000, 16'h0000, 0, 67, 175, 1'b0);
    run_phase(16'hFFFF, rand16(), rand16(), rand16(), 36, 36, 175, 1'b0);
    run_phase(16'd3, one_hot16(), one_hot16(), one_hot16(), 0, 0, 175, 1'b1);
    run_phase(16'd257, rand16(), rand16(), rand16(), 67, 0, 175, 1'b0);
    run_phase(16'($urandom_range(256, 1)), rand16(), rand16(), rand16(), 0, 67,
              175, 1'b0);
    run_phase(16'd128, rand16(), rand16(), rand16(), 36, 36, 175, 1'b0);
    run_phase(16'd256, one_hot16(), one_hot16(), one_hot16(), 0, 0, 175, 1'b0);

    wait_drained();
    $display("covered %0d loads and %0d queries (%0d exact hits), %0d results checked",
             n_loads, n_queries, n_hits, n_results);
    $display("entry counts 0 to 511, flag masks empty, single-bit, full and random");
    if (err_cnt == 0) begin
      $display("char_class_table_lookup test passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("char_class_table_lookup test failed");
    end
    $finish;
  end

endmodule
